// ===== design/msgd_pkg.sv =====
// Shared types, widths and arithmetic helpers for the perceptron trainer.
// Used by every module of the block; depends on nothing else.
package msgd_pkg;

  localparam int FRAC_BITS = 12;
  localparam int ONE       = 1 << FRAC_BITS;
  localparam int ACT_W     = FRAC_BITS + 1;
  localparam int W_W       = 16;
  localparam int LR_W      = 13;
  localparam int PIDX_W    = 4;
  localparam int PRE_W     = 22;
  localparam int PH_W      = ACT_W + 1 + W_W;
  localparam int PO_W      = ACT_W + 1 + W_W;
  localparam int DSIG_W    = 12;
  localparam int ERR_W     = ACT_W + 2;
  localparam int DOUT_W    = 16;
  localparam int DLR_W     = DOUT_W + LR_W + 1;
  localparam int T_W       = 20;
  localparam int DH_W      = 16;
  localparam int DHLR_W    = DH_W + LR_W + 1;
  localparam int EP_W      = ACT_W + 1 + DLR_W;
  localparam int SIG_OFFSET = 8 * ONE;

  localparam logic signed [47:0] W_MAX = 48'sd32767;
  localparam logic signed [47:0] W_MIN = -48'sd32768;

  typedef enum logic [3:0] {
    ST_IDLE, ST_HMUL, ST_HSUM, ST_HSIG, ST_OMUL, ST_OSUM, ST_OSIG, ST_ODSIG,
    ST_DOUT, ST_DLR, ST_UPD1, ST_UPD2, ST_UPD3, ST_UPD4, ST_RESP
  } state_t;

  typedef struct packed {
    state_t                   st;
    logic                     ld_en;
    logic [PIDX_W-1:0]        ld_idx;
    logic signed [W_W-1:0]    ld_val;
  } ctl_t;

  // Shift right by s with rounding half towards plus infinity.
  function automatic logic signed [47:0] round_shift(input logic signed [47:0] v,
                                                     input int unsigned s);
    return (v + (48'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic logic signed [W_W-1:0] sat16(input logic signed [47:0] v);
    logic signed [W_W-1:0] res;
    if (v > W_MAX) res = W_MAX[W_W-1:0];
    else if (v < W_MIN) res = W_MIN[W_W-1:0];
    else res = v[W_W-1:0];
    return res;
  endfunction

  // Sigmoid derivative y*(1-y); y never exceeds one, so the result fits.
  function automatic logic [DSIG_W-1:0] dsig(input logic [ACT_W-1:0] y);
    logic [2*ACT_W-1:0] p;
    p = (2*ACT_W)'(y) * (2*ACT_W)'(ACT_W'(ONE) - y);
    return p[FRAC_BITS+DSIG_W-1:FRAC_BITS];
  endfunction

  // Long division by shift and subtract, used only while building the table.
  function automatic longint unsigned udiv(input longint unsigned n,
                                           input longint unsigned d);
    longint unsigned q;
    longint unsigned rem;
    q = 0;
    rem = 0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], n[b]};
      if (rem >= d) begin
        rem = rem - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // One sigmoid table entry, evaluated at the centre of its bin.
  function automatic logic [ACT_W-1:0] sig_entry(input int unsigned i,
                                                 input int unsigned depth);
    longint unsigned pw [15];
    longint unsigned t;
    longint unsigned r;
    longint unsigned den;
    longint unsigned q;
    longint          xv;
    pw[0] = 64'd4293918848;
    for (int k = 1; k < 15; k++)
      pw[k] = (pw[k-1] * pw[k-1] + 64'd2147483648) >> 32;
    xv = longint'(udiv(64'(2 * i + 1) * 64'd32768, 64'(depth))) - 64'sd32768;
    t = (xv < 0) ? 64'(-xv) : 64'(xv);
    r = 64'd1 << 32;
    for (int k = 0; k < 15; k++)
      if (t[k]) r = (r * pw[k] + 64'd2147483648) >> 32;
    den = (64'd1 << 32) + r;
    if (xv >= 0) q = udiv((64'(ONE) << 32) + (den >> 1), den);
    else q = udiv(64'(ONE) * r + (den >> 1), den);
    return ACT_W'(q);
  endfunction

endpackage

// ===== design/msgd_sigmoid.sv =====
// Sigmoid lookup: bin index from a pre-activation and a constant table.
// Depends on msgd_pkg.
module msgd_sigmoid #(
  parameter int SIG_TABLE_DEPTH = 256
) (
  input  logic signed [msgd_pkg::PRE_W-1:0] pre,
  output logic        [msgd_pkg::ACT_W-1:0] act
);
  import msgd_pkg::*;

  localparam int IDX_W = $clog2(SIG_TABLE_DEPTH);
  localparam int PW    = PRE_W + IDX_W + 2;

  logic [ACT_W-1:0]      rom [SIG_TABLE_DEPTH];
  logic signed [PRE_W:0] off;
  logic [PW-1:0]         prod;
  logic [PW-1:0]         idx_full;
  logic [IDX_W-1:0]      idx;

  for (genvar g = 0; g < SIG_TABLE_DEPTH; g++) begin : g_rom
    assign rom[g] = sig_entry(g, SIG_TABLE_DEPTH);
  end

  always_comb begin
    off      = $signed({pre[PRE_W-1], pre}) + $signed((PRE_W+1)'(SIG_OFFSET));
    prod     = PW'(off[PRE_W-1:0]) * PW'(SIG_TABLE_DEPTH);
    idx_full = prod >> (FRAC_BITS + 4);
    // Below the table clamps to the first entry, above it to the last.
    if (off[PRE_W]) idx = '0;
    else if (idx_full > PW'(SIG_TABLE_DEPTH - 1)) idx = IDX_W'(SIG_TABLE_DEPTH - 1);
    else idx = idx_full[IDX_W-1:0];
    act = rom[idx];
  end

endmodule

// ===== design/msgd_lane.sv =====
// One hidden unit: its weights, forward product terms, delta and updates.
// Depends on msgd_pkg and msgd_sigmoid.
module msgd_lane #(
  parameter int NUM_IN          = 2,
  parameter int NUM_HIDDEN      = 2,
  parameter int LANE            = 0,
  parameter int SIG_TABLE_DEPTH = 256
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  msgd_pkg::ctl_t                     ctl,
  input  logic        [msgd_pkg::ACT_W-1:0]  x [NUM_IN],
  input  logic        [msgd_pkg::LR_W-1:0]   lr,
  input  logic signed [msgd_pkg::DOUT_W-1:0] dout,
  input  logic signed [msgd_pkg::DLR_W-1:0]  dlr,
  output logic signed [msgd_pkg::PO_W-1:0]   prod_o
);
  import msgd_pkg::*;

  localparam int ACC_W  = 36;
  localparam int HB_IDX = NUM_IN * NUM_HIDDEN + LANE;
  localparam int OW_IDX = NUM_IN * NUM_HIDDEN + NUM_HIDDEN + LANE;

  logic signed [W_W-1:0]    hw_r [NUM_IN];
  logic signed [W_W-1:0]    hb_r;
  logic signed [W_W-1:0]    ow_r;
  logic signed [PH_W-1:0]   prod_h_r [NUM_IN];
  logic signed [PRE_W-1:0]  pre_r;
  logic        [ACT_W-1:0]  h_r;
  logic signed [PO_W-1:0]   prod_o_r;
  logic        [DSIG_W-1:0] hd_r;
  logic signed [T_W-1:0]    t_r;
  logic signed [EP_W-1:0]   owp_r;
  logic signed [DH_W-1:0]   dh_r;
  logic signed [DHLR_W-1:0] dhlr_r;
  logic signed [EP_W-1:0]   hwp_r [NUM_IN];

  logic signed [ACC_W-1:0]  acc;
  logic        [ACT_W-1:0]  act_h;

  always_comb begin
    acc = ACC_W'(hb_r) <<< FRAC_BITS;
    for (int k = 0; k < NUM_IN; k++)
      acc = acc + ACC_W'(prod_h_r[k]);
  end

  msgd_sigmoid #(.SIG_TABLE_DEPTH(SIG_TABLE_DEPTH)) u_sig (.pre(pre_r), .act(act_h));

  assign prod_o = prod_o_r;

  // Parameters: cleared at reset, written by loads or by the update steps.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_IN; k++) hw_r[k] <= '0;
      hb_r <= '0;
      ow_r <= '0;
    end else begin
      for (int k = 0; k < NUM_IN; k++) begin
        if (ctl.ld_en && int'(ctl.ld_idx) == k * NUM_HIDDEN + LANE)
          hw_r[k] <= ctl.ld_val;
        else if (ctl.st == ST_UPD4)
          hw_r[k] <= sat16(48'(hw_r[k]) + round_shift(48'(hwp_r[k]), 2 * FRAC_BITS));
      end
      if (ctl.ld_en && int'(ctl.ld_idx) == HB_IDX)
        hb_r <= ctl.ld_val;
      else if (ctl.st == ST_UPD3)
        hb_r <= sat16(48'(hb_r) + round_shift(48'(dhlr_r), FRAC_BITS));
      if (ctl.ld_en && int'(ctl.ld_idx) == OW_IDX)
        ow_r <= ctl.ld_val;
      else if (ctl.st == ST_UPD2)
        ow_r <= sat16(48'(ow_r) + round_shift(48'(owp_r), 2 * FRAC_BITS));
    end
  end

  always_ff @(posedge clk) begin
    unique case (ctl.st)
      ST_HMUL: begin
        for (int k = 0; k < NUM_IN; k++)
          prod_h_r[k] <= $signed({1'b0, x[k]}) * hw_r[k];
      end
      ST_HSUM: pre_r <= PRE_W'(round_shift(48'(acc), FRAC_BITS));
      ST_HSIG: h_r <= act_h;
      ST_OMUL: begin
        prod_o_r <= $signed({1'b0, h_r}) * ow_r;
        hd_r     <= dsig(h_r);
      end
      // The output weight here is still the one from before this item's update.
      ST_DLR: t_r <= T_W'(round_shift(48'(32'(dout) * 32'(ow_r)), FRAC_BITS));
      ST_UPD1: begin
        owp_r <= $signed({1'b0, h_r}) * dlr;
        dh_r  <= DH_W'(round_shift(48'(34'(t_r) * 34'($signed({1'b0, hd_r}))),
                                   FRAC_BITS));
      end
      ST_UPD2: dhlr_r <= dh_r * $signed({1'b0, lr});
      ST_UPD3: begin
        for (int k = 0; k < NUM_IN; k++)
          hwp_r[k] <= $signed({1'b0, x[k]}) * dhlr_r;
      end
      default: ;
    endcase
  end

endmodule

// ===== design/msgd_out.sv =====
// Output unit: merges the lane products, output sigmoid, error and delta.
// Depends on msgd_pkg and msgd_sigmoid.
module msgd_out #(
  parameter int NUM_IN          = 2,
  parameter int NUM_HIDDEN      = 2,
  parameter int SIG_TABLE_DEPTH = 256
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  msgd_pkg::ctl_t                     ctl,
  input  logic signed [msgd_pkg::PO_W-1:0]   prod_o [NUM_HIDDEN],
  input  logic        [msgd_pkg::ACT_W-1:0]  tgt,
  input  logic        [msgd_pkg::LR_W-1:0]   lr,
  output logic        [msgd_pkg::ACT_W-1:0]  o,
  output logic signed [msgd_pkg::ERR_W-1:0]  err,
  output logic signed [msgd_pkg::DOUT_W-1:0] dout,
  output logic signed [msgd_pkg::DLR_W-1:0]  dlr
);
  import msgd_pkg::*;

  localparam int ACC_W  = 36;
  localparam int OB_IDX = NUM_IN * NUM_HIDDEN + 2 * NUM_HIDDEN;

  logic signed [W_W-1:0]    ob_r;
  logic signed [PRE_W-1:0]  pre_r;
  logic        [ACT_W-1:0]  o_r;
  logic signed [ERR_W-1:0]  err_r;
  logic        [DSIG_W-1:0] dso_r;
  logic signed [DOUT_W-1:0] dout_r;
  logic signed [DLR_W-1:0]  dlr_r;

  logic signed [ACC_W-1:0]  acc;
  logic        [ACT_W-1:0]  act_o;

  always_comb begin
    acc = ACC_W'(ob_r) <<< FRAC_BITS;
    for (int j = 0; j < NUM_HIDDEN; j++)
      acc = acc + ACC_W'(prod_o[j]);
  end

  msgd_sigmoid #(.SIG_TABLE_DEPTH(SIG_TABLE_DEPTH)) u_sig (.pre(pre_r), .act(act_o));

  assign o    = o_r;
  assign err  = err_r;
  assign dout = dout_r;
  assign dlr  = dlr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ob_r <= '0;
    end else if (ctl.ld_en && int'(ctl.ld_idx) == OB_IDX) begin
      ob_r <= ctl.ld_val;
    end else if (ctl.st == ST_UPD1) begin
      ob_r <= sat16(48'(ob_r) + round_shift(48'(dlr_r), FRAC_BITS));
    end
  end

  always_ff @(posedge clk) begin
    unique case (ctl.st)
      ST_OSUM: pre_r <= PRE_W'(round_shift(48'(acc), FRAC_BITS));
      ST_OSIG: begin
        o_r   <= act_o;
        err_r <= $signed({2'b00, tgt}) - $signed({2'b00, act_o});
      end
      ST_ODSIG: dso_r <= dsig(o_r);
      ST_DOUT: dout_r <= DOUT_W'(round_shift(48'(32'(err_r) * 32'($signed({1'b0, dso_r}))),
                                             FRAC_BITS));
      ST_DLR: dlr_r <= dout_r * $signed({1'b0, lr});
      default: ;
    endcase
  end

endmodule

// ===== design/mlp_sgd_train_step.sv =====
// Top level of the online perceptron trainer: sequencer, lanes, output unit.
// Depends on msgd_pkg, msgd_lane and msgd_out.
//
// Usage. The input channel carries training items (tuser bit 0 low) and
// load items (tuser bit 0 high). A load item writes one weight or bias and
// is acknowledged by a result with out_tuser high and zero data. A training
// item runs the forward pass, the deltas and the weight updates, then gives
// the output from before the update and its error.
// Timing: a load result is valid the cycle after the item is taken, so loads
// can stream at one per cycle while the output is free. A training item is
// walked by the sequencer through the multiply, sum, table and update steps,
// each behind a register, and no new item is taken until its result is sent.
// The hidden units are computed side by side, one lane each.
// Stalls: the result sits in an output register; a waiting result only holds
// off the next item while that register is still full.
// Reset clears every weight and bias to zero and the learning rate to 410.
// cfg_we writes the learning rate; write it only while the block is idle.
module mlp_sgd_train_step #(
  parameter int NUM_IN          = 2,
  parameter int NUM_HIDDEN      = 2,
  parameter int SIG_TABLE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [12:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  // in_a[12:0], in_b[25:13], target[38:26], param_index[42:39],
  // param_value[58:43], zero[63:59]
  input  logic [63:0] in_tdata,
  // req_type[0]
  input  logic [0:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // out_activation[12:0], out_error[26:13], zero[31:27]
  output logic [31:0] out_tdata,
  // was_load[0]
  output logic [0:0]  out_tuser
);
  import msgd_pkg::*;

  localparam logic [LR_W-1:0] LR_RESET = LR_W'(410);

  state_t state_r, state_nxt;
  ctl_t   ctl;

  logic [LR_W-1:0]          lr_r;
  logic [ACT_W-1:0]         x_r [NUM_IN];
  logic [ACT_W-1:0]         tgt_r;
  logic                     out_valid_r;
  logic [ACT_W-1:0]         out_act_r;
  logic [ERR_W-2:0]         out_err_r;
  logic                     out_load_r;

  logic                     in_acc;
  logic                     out_free;
  logic                     resp_fire;
  logic signed [PO_W-1:0]   prod_o [NUM_HIDDEN];
  logic [ACT_W-1:0]         o;
  logic signed [ERR_W-1:0]  err;
  logic signed [DOUT_W-1:0] dout;
  logic signed [DLR_W-1:0]  dlr;

  assign out_free = !out_valid_r || out_tready;
  assign in_acc   = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_acc && !in_tuser[0]) state_nxt = ST_HMUL;
      ST_HMUL:  state_nxt = ST_HSUM;
      ST_HSUM:  state_nxt = ST_HSIG;
      ST_HSIG:  state_nxt = ST_OMUL;
      ST_OMUL:  state_nxt = ST_OSUM;
      ST_OSUM:  state_nxt = ST_OSIG;
      ST_OSIG:  state_nxt = ST_ODSIG;
      ST_ODSIG: state_nxt = ST_DOUT;
      ST_DOUT:  state_nxt = ST_DLR;
      ST_DLR:   state_nxt = ST_UPD1;
      ST_UPD1:  state_nxt = ST_UPD2;
      ST_UPD2:  state_nxt = ST_UPD3;
      ST_UPD3:  state_nxt = ST_UPD4;
      ST_UPD4:  state_nxt = ST_RESP;
      ST_RESP:  if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready  = (state_r == ST_IDLE) && out_free;
    resp_fire  = (state_r == ST_RESP) && out_free;
    ctl.st     = state_r;
    ctl.ld_en  = in_tvalid && (state_r == ST_IDLE) && out_free && in_tuser[0];
    ctl.ld_idx = in_tdata[42:39];
    ctl.ld_val = $signed(in_tdata[58:43]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      lr_r        <= LR_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) lr_r <= cfg_wdata;
      if ((in_acc && in_tuser[0]) || resp_fire) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && !in_tuser[0]) begin
      for (int k = 0; k < NUM_IN; k++) begin
        if (k == 0) x_r[k] <= in_tdata[12:0];
        else if (k == 1) x_r[k] <= in_tdata[25:13];
        else x_r[k] <= '0;
      end
      tgt_r <= in_tdata[38:26];
    end
    if (in_acc && in_tuser[0]) begin
      out_act_r  <= '0;
      out_err_r  <= '0;
      out_load_r <= 1'b1;
    end else if (resp_fire) begin
      out_act_r  <= o;
      out_err_r  <= err[ERR_W-2:0];
      out_load_r <= 1'b0;
    end
  end

  for (genvar j = 0; j < NUM_HIDDEN; j++) begin : g_lane
    msgd_lane #(
      .NUM_IN(NUM_IN), .NUM_HIDDEN(NUM_HIDDEN), .LANE(j),
      .SIG_TABLE_DEPTH(SIG_TABLE_DEPTH)
    ) u_lane (
      .clk(clk), .rst_n(rst_n), .ctl(ctl), .x(x_r), .lr(lr_r),
      .dout(dout), .dlr(dlr), .prod_o(prod_o[j])
    );
  end

  msgd_out #(
    .NUM_IN(NUM_IN), .NUM_HIDDEN(NUM_HIDDEN), .SIG_TABLE_DEPTH(SIG_TABLE_DEPTH)
  ) u_out (
    .clk(clk), .rst_n(rst_n), .ctl(ctl), .prod_o(prod_o), .tgt(tgt_r), .lr(lr_r),
    .o(o), .err(err), .dout(dout), .dlr(dlr)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_err_r, out_act_r};
  assign out_tuser  = out_load_r;

  a_train_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !in_tuser[0] |=> state_r == ST_HMUL)
    else $error("training item did not start the sequence");

  a_load_ack: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_tuser[0] |=> out_tvalid && out_tuser[0] && out_tdata == 32'd0)
    else $error("load item not acknowledged with an empty result");

  a_train_result: assert property (@(posedge clk) disable iff (!rst_n)
    resp_fire |=> out_tvalid && !out_tuser[0] && state_r == ST_IDLE)
    else $error("training result not presented");

endmodule
